### rtl/frl_pkg.sv
// ----------------------------------------------------------------------------
// frl_pkg: shared types and constants for the file range to LBA mapper
// Result word layout, status and kind codes, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package frl_pkg;

  // Fixed result field widths.
  localparam int unsigned SECTOR_W = 39;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Width of the covered byte accumulator.
  localparam int unsigned COVER_W = 49;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LENGTH = 1'b1;

  // Output queue depth in words; a step can push two words at once.
  localparam int unsigned OQ_DEPTH = 4;

  typedef enum logic {
    KIND_EXTENT = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_COUNT = 2'd1,
    STAT_HOLE      = 2'd2
  } status_e;

  // Control bits that travel down the pipeline with each slot.
  typedef struct packed {
    logic valid;
    logic hit;
    logic last;
  } ctl_t;

  // One result word.
  typedef struct packed {
    kind_e                kind;
    logic [SECTOR_W-1:0]  start_sector;
    logic [COUNT_W-1:0]   sector_count;
    status_e              status;
    logic                 last;
  } word_t;

endpackage

### rtl/frl_clip.sv
// ----------------------------------------------------------------------------
// frl_clip: input register and range clipping
// Registers the incoming extent, then intersects it with the configured range
// and registers the start and end offsets of the overlap within the extent.
// ----------------------------------------------------------------------------
module frl_clip #(
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 in_valid_i,
  input  logic [ADDR_BITS-1:0] ext_logical_i,
  input  logic [ADDR_BITS-1:0] ext_physical_i,
  input  logic [ADDR_BITS-1:0] ext_length_i,
  input  logic                 ext_last_i,
  input  logic [ADDR_BITS-1:0] range_offset_i,
  input  logic [ADDR_BITS-1:0] range_length_i,
  output frl_pkg::ctl_t        ctl_o,
  output logic [ADDR_BITS-1:0] physical_o,
  output logic [ADDR_BITS-1:0] delta_s_o,
  output logic [ADDR_BITS-1:0] delta_e_o
);
  import frl_pkg::*;

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned PW = ADDR_BITS + 1;

  logic          in_vld_q;
  logic          in_last_q;
  logic [AW-1:0] log_q;
  logic [AW-1:0] phys_q;
  logic [AW-1:0] len_q;

  logic [PW-1:0] r_end;
  logic [PW-1:0] e_end;
  logic [PW-1:0] ov_start;
  logic [PW-1:0] ov_end;
  logic          hit;

  ctl_t          ctl_q;
  logic [AW-1:0] phys_s1_q;
  logic [AW-1:0] dlt_s_q;
  logic [AW-1:0] dlt_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv_i) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && in_valid_i) begin
      log_q     <= ext_logical_i;
      phys_q    <= ext_physical_i;
      len_q     <= ext_length_i;
      in_last_q <= ext_last_i;
    end
  end

  // Both ends are one bit wider so the sums never wrap.
  assign r_end = PW'(range_offset_i) + PW'(range_length_i);
  assign e_end = PW'(log_q) + PW'(len_q);

  assign hit = (range_length_i != '0) && (len_q != '0) &&
               (e_end > PW'(range_offset_i)) && (PW'(log_q) < r_end);

  assign ov_start = (log_q > range_offset_i) ? PW'(log_q) : PW'(range_offset_i);
  assign ov_end   = (e_end < r_end) ? e_end : r_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= '{valid: in_vld_q, hit: hit, last: in_last_q};
    end
  end

  // On overlap, start offset < extent length and end offset <= extent length.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      phys_s1_q <= phys_q;
      dlt_s_q   <= AW'(ov_start - PW'(log_q));
      dlt_e_q   <= AW'(ov_end - PW'(log_q));
    end
  end

  assign ctl_o      = ctl_q;
  assign physical_o = phys_s1_q;
  assign delta_s_o  = dlt_s_q;
  assign delta_e_o  = dlt_e_q;

endmodule

### rtl/frl_xlate.sv
// ----------------------------------------------------------------------------
// frl_xlate: physical translation and sector arithmetic
// Forms the physical start and end of the overlap, then the start sector and
// the rounded-up sector count, flagging counts that do not fit in 32 bits.
// ----------------------------------------------------------------------------
module frl_xlate #(
  parameter int unsigned SECTOR_BYTES = 512,
  parameter int unsigned ADDR_BITS    = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  frl_pkg::ctl_t                  ctl_i,
  input  logic [ADDR_BITS-1:0]           physical_i,
  input  logic [ADDR_BITS-1:0]           delta_s_i,
  input  logic [ADDR_BITS-1:0]           delta_e_i,
  output frl_pkg::ctl_t                  ctl_o,
  output logic [frl_pkg::SECTOR_W-1:0]   start_sector_o,
  output logic [frl_pkg::COUNT_W-1:0]    sector_count_o,
  output logic                           count_bad_o,
  output logic [ADDR_BITS-1:0]           ov_len_o
);
  import frl_pkg::*;

  localparam int unsigned AW   = ADDR_BITS;
  localparam int unsigned PW   = ADDR_BITS + 1;
  localparam int unsigned SH   = $clog2(SECTOR_BYTES);
  localparam int unsigned CNTW = (PW - SH + 1 > COUNT_W + 1) ? PW - SH + 1 : COUNT_W + 1;

  ctl_t          ctl_a_q;
  logic [PW-1:0] phys_a_q;
  logic [PW-1:0] pend_a_q;
  logic [AW-1:0] len_a_q;

  logic [PW-1:0]   p_hi;
  logic [PW-1:0]   e_hi;
  logic            round_up;
  logic [CNTW-1:0] cnt;

  ctl_t                ctl_b_q;
  logic [SECTOR_W-1:0] start_q;
  logic [COUNT_W-1:0]  count_q;
  logic                bad_q;
  logic [AW-1:0]       len_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (adv_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      phys_a_q <= PW'(physical_i) + PW'(delta_s_i);
      pend_a_q <= PW'(physical_i) + PW'(delta_e_i);
      len_a_q  <= delta_e_i - delta_s_i;
    end
  end

  // Sector size is a power of two, so sector numbers are plain shifts.
  assign p_hi     = phys_a_q >> SH;
  assign e_hi     = pend_a_q >> SH;
  assign round_up = |pend_a_q[SH-1:0];
  assign cnt      = CNTW'(e_hi) - CNTW'(p_hi) + CNTW'(round_up);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      start_q <= SECTOR_W'(p_hi);
      count_q <= cnt[COUNT_W-1:0];
      bad_q   <= |cnt[CNTW-1:COUNT_W];
      len_b_q <= len_a_q;
    end
  end

  assign ctl_o          = ctl_b_q;
  assign start_sector_o = start_q;
  assign sector_count_o = count_q;
  assign count_bad_o    = bad_q;
  assign ov_len_o       = len_b_q;

endmodule

### rtl/frl_track.sv
// ----------------------------------------------------------------------------
// frl_track: list state and result formation
// Keeps the covered byte total and the failure flag of the current list and
// forms the extent word of each hit slot and the status word of the last slot.
// ----------------------------------------------------------------------------
module frl_track #(
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  frl_pkg::ctl_t                ctl_i,
  input  logic [frl_pkg::SECTOR_W-1:0] start_sector_i,
  input  logic [frl_pkg::COUNT_W-1:0]  sector_count_i,
  input  logic                         count_bad_i,
  input  logic [ADDR_BITS-1:0]         ov_len_i,
  input  logic [ADDR_BITS-1:0]         range_length_i,
  output logic                         push_a_o,
  output frl_pkg::word_t               word_a_o,
  output logic                         push_b_o,
  output frl_pkg::word_t               word_b_o
);
  import frl_pkg::*;

  localparam int unsigned CMPW = (ADDR_BITS > COVER_W) ? ADDR_BITS : COVER_W;
  localparam int unsigned SUMW = CMPW + 1;

  logic [COVER_W-1:0] covered_q;
  logic [COVER_W-1:0] covered_d;
  logic               failed_q;
  logic               failed_d;

  logic               act;
  logic               live;
  logic               emit;
  logic               fail_now;
  logic [SUMW-1:0]    sum;
  logic               sat;
  logic [COVER_W-1:0] cov_new;
  logic               hole;
  status_e            stat;

  assign act      = adv_i && ctl_i.valid;
  assign live     = ctl_i.hit && !failed_q;
  assign emit     = act && live && !count_bad_i;
  assign fail_now = failed_q || (live && count_bad_i);

  // Covered bytes saturate at the top of the accumulator.
  assign sum     = SUMW'(covered_q) + SUMW'(ov_len_i);
  assign sat     = |sum[SUMW-1:COVER_W];
  assign cov_new = !emit ? covered_q : (sat ? '1 : sum[COVER_W-1:0]);
  assign hole    = CMPW'(cov_new) < CMPW'(range_length_i);

  always_comb begin
    if (range_length_i == '0) begin
      stat = STAT_OK;
    end else if (fail_now) begin
      stat = STAT_BAD_COUNT;
    end else if (hole) begin
      stat = STAT_HOLE;
    end else begin
      stat = STAT_OK;
    end
  end

  always_comb begin
    covered_d = covered_q;
    failed_d  = failed_q;
    if (act) begin
      if (ctl_i.last) begin
        covered_d = '0;
        failed_d  = 1'b0;
      end else begin
        covered_d = cov_new;
        failed_d  = fail_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      covered_q <= '0;
      failed_q  <= 1'b0;
    end else begin
      covered_q <= covered_d;
      failed_q  <= failed_d;
    end
  end

  assign push_a_o = emit;
  assign word_a_o = '{kind: KIND_EXTENT, start_sector: start_sector_i,
                      sector_count: sector_count_i, status: STAT_OK, last: 1'b0};

  assign push_b_o = act && ctl_i.last;
  assign word_b_o = '{kind: KIND_STATUS, start_sector: '0, sector_count: '0,
                      status: stat, last: 1'b1};

endmodule

### rtl/frl_outq.sv
// ----------------------------------------------------------------------------
// frl_outq: result word queue
// Small register queue that takes up to two words per cycle and hands one word
// per cycle to the output when not stalled, and says when the pipeline moves.
// ----------------------------------------------------------------------------
module frl_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_a_i,
  input  frl_pkg::word_t word_a_i,
  input  logic           push_b_i,
  input  frl_pkg::word_t word_b_i,
  output logic           room2_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output frl_pkg::word_t out_word_o
);
  import frl_pkg::*;

  localparam int unsigned PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  word_t             mem_q [OQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PTR_W-1:0]  wr_b;
  logic              pop;

  assign pop  = out_valid_o && !out_stall_i;
  assign wr_b = wr_ptr_q + PTR_W'(push_a_i);

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_ptr_q] <= word_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_b] <= word_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_a_i) + PTR_W'(push_b_i);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      cnt_q    <= cnt_q + CNT_W'(push_a_i) + CNT_W'(push_b_i) - CNT_W'(pop);
    end
  end

  assign room2_o     = cnt_q <= CNT_W'(OQ_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_word_o  = mem_q[rd_ptr_q];

endmodule

### rtl/file_range_to_lba_extents.sv
// ----------------------------------------------------------------------------
// file_range_to_lba_extents: file byte range to device sector extents
// Clips streamed file extents to a configured range and emits start sector and
// sector count words, followed by a final status word on the last extent.
// ----------------------------------------------------------------------------
// Usage. Write range_offset (index 0) and range_length (index 1) through the
// configuration port while the block is idle. Then stream extents on the input
// channel (valid/stall); the extent flagged ext_last closes the list. Each
// overlapping extent yields one sector extent word unless its count, or one
// earlier in the list, was invalid; the last also yields a status word (ok,
// count invalid, or hole); then the covered byte total and failure flag clear.
//
// Throughput is one extent per cycle unless the pipeline stalls. The input
// register, clipping, translation and sector stages form a pipeline that
// moves as one unit; each result word is formed after the sector stage and
// passes through the output queue to the output channel. A last extent that
// yields an extent word produces two words, which the output takes one at a
// time. The rate is set by the output queue: the pipeline moves only while
// the queue has room for two words, so when the receiver stalls, the queue
// fills and the input stall rises, and words are held in order until taken.
// Reset clears the range registers, the list state, pipeline and queue.
// SECTOR_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module file_range_to_lba_extents #(
  parameter int unsigned SECTOR_BYTES = 512,
  parameter int unsigned ADDR_BITS    = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [frl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ADDR_BITS-1:0]           cfg_wdata_i,

  // Extent input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ADDR_BITS-1:0]           ext_logical_i,
  input  logic [ADDR_BITS-1:0]           ext_physical_i,
  input  logic [ADDR_BITS-1:0]           ext_length_i,
  input  logic                           ext_last_i,

  // Result output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           result_kind_o,
  output logic [frl_pkg::SECTOR_W-1:0]   start_sector_o,
  output logic [frl_pkg::COUNT_W-1:0]    sector_count_o,
  output logic [frl_pkg::STATUS_W-1:0]   status_o,
  output logic                           last_o
);
  import frl_pkg::*;

  logic [ADDR_BITS-1:0] range_offset_q;
  logic [ADDR_BITS-1:0] range_length_q;

  logic                 adv;

  ctl_t                 clip_ctl;
  logic [ADDR_BITS-1:0] clip_phys;
  logic [ADDR_BITS-1:0] clip_dlt_s;
  logic [ADDR_BITS-1:0] clip_dlt_e;

  ctl_t                 xl_ctl;
  logic [SECTOR_W-1:0]  xl_start;
  logic [COUNT_W-1:0]   xl_count;
  logic                 xl_bad;
  logic [ADDR_BITS-1:0] xl_len;

  logic                 push_a;
  logic                 push_b;
  word_t                word_a;
  word_t                word_b;
  word_t                out_word;

  // Range registers. The user must make writes only while no list is in
  // flight, so every stage sees stable values; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_offset_q <= '0;
      range_length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANGE_OFFSET: range_offset_q <= cfg_wdata_i;
        CFG_RANGE_LENGTH: range_length_q <= cfg_wdata_i;
      endcase
    end
  end

  // The whole pipeline advances together whenever the queue can absorb the
  // two words the final stage may produce.
  assign in_stall_o = !adv;

  frl_clip #(
    .ADDR_BITS(ADDR_BITS)
  ) u_clip (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_valid_i    (in_valid_i),
    .ext_logical_i (ext_logical_i),
    .ext_physical_i(ext_physical_i),
    .ext_length_i  (ext_length_i),
    .ext_last_i    (ext_last_i),
    .range_offset_i(range_offset_q),
    .range_length_i(range_length_q),
    .ctl_o         (clip_ctl),
    .physical_o    (clip_phys),
    .delta_s_o     (clip_dlt_s),
    .delta_e_o     (clip_dlt_e)
  );

  frl_xlate #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_xlate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .ctl_i         (clip_ctl),
    .physical_i    (clip_phys),
    .delta_s_i     (clip_dlt_s),
    .delta_e_i     (clip_dlt_e),
    .ctl_o         (xl_ctl),
    .start_sector_o(xl_start),
    .sector_count_o(xl_count),
    .count_bad_o   (xl_bad),
    .ov_len_o      (xl_len)
  );

  frl_track #(
    .ADDR_BITS(ADDR_BITS)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .ctl_i         (xl_ctl),
    .start_sector_i(xl_start),
    .sector_count_i(xl_count),
    .count_bad_i   (xl_bad),
    .ov_len_i      (xl_len),
    .range_length_i(range_length_q),
    .push_a_o      (push_a),
    .word_a_o      (word_a),
    .push_b_o      (push_b),
    .word_b_o      (word_b)
  );

  frl_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_a_i   (push_a),
    .word_a_i   (word_a),
    .push_b_i   (push_b),
    .word_b_i   (word_b),
    .room2_o    (adv),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word)
  );

  assign result_kind_o  = out_word.kind;
  assign start_sector_o = out_word.start_sector;
  assign sector_count_o = out_word.sector_count;
  assign status_o       = out_word.status;
  assign last_o         = out_word.last;

endmodule
